/* rtl/core/pbd_pkg.sv */
// Shared types and codes for the polygon border distance block.
// No dependencies; pbd_if and polygon_border_distance import it.
package pbd_pkg;

  localparam int X_W     = 24;
  localparam int POS_W   = 10;
  localparam int DIST_W  = 36;
  localparam int SHOWN_W = 11;
  localparam int STAT_W  = 3;

  localparam logic [STAT_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_RANGE     = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_TOO_FEW   = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_NO_POLY   = 3'd4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic                    op;
    logic signed [X_W-1:0]   x;
    logic signed [X_W-1:0]   y;
    logic                    last_vertex;
    logic [POS_W-1:0]        pos_a;
    logic [POS_W-1:0]        pos_b;
  } pbd_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DIST_W-1:0]  distance;
    logic [SHOWN_W-1:0] vertex_count;
  } pbd_out_t;

endpackage

/* rtl/core/pbd_if.sv */
// Valid/ready channels for input items and result items.
// Depends on pbd_pkg for the payload types.
interface pbd_in_if;
  import pbd_pkg::*;
  logic    valid;
  logic    ready;
  pbd_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pbd_out_if;
  import pbd_pkg::*;
  logic     valid;
  logic     ready;
  pbd_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/polygon_border_distance.sv */
// Polygon border distance: top level with prefix-length memory and sequencer.
// Depends on pbd_pkg, pbd_if and pbd_edge.
//
// Loads a polygon one vertex beat at a time. The running border length at each
// vertex position is kept in a table memory with one read and one write port,
// and the block answers border distance queries between two positions,
// wrapping through vertex 0. One beat is in work at a time and the input is
// ready only while the sequencer idles. A finished result sits in the output
// register while the next beat is accepted, and it holds the sequencer only
// while an older result still waits. A load that adds one edge loads the edge
// operands on accept, runs shift-add squaring and a one-bit root in pbd_edge,
// then emits and returns to idle. Closing with a new vertex also adds the
// closing edge. Closing with a duplicate of vertex 0 runs only the closing
// edge. Error cases, the first vertex and queries that need no table read go
// straight to emit. Other queries read the table three times (both positions,
// then entry 0), then form the distance and emit. The table needs no clearing,
// because only entries written for the current polygon are read.
module polygon_border_distance #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 24
) (
  input logic       clk,
  input logic       rst,
  pbd_in_if.sink    item,
  pbd_out_if.source result
);
  import pbd_pkg::*;

  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int EL_W  = COORD_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_EDGE, S_CLOSE, S_RA, S_RB, S_R0, S_QD, S_EMIT
  } state_t;

  state_t state;

  logic [DIST_W-1:0] table_mem [MAX_VERTICES];
  logic [DIST_W-1:0] rdata;
  logic [AW-1:0]     raddr, waddr;
  logic [DIST_W-1:0] wdata;
  logic              wen;

  logic [CNT_W-1:0]  count;
  logic [DIST_W-1:0] running_length;
  logic              closed;
  logic signed [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y, cur_x, cur_y;
  logic              cur_last;
  logic [AW-1:0]     qa, qb;
  logic [DIST_W-1:0] la, lb;

  logic [STAT_W-1:0] pend_status;
  logic [DIST_W-1:0] pend_dist;
  logic [CNT_W-1:0]  pend_shown;

  // Coordinate extraction
  logic signed [COORD_BITS-1:0] px, py;
  if (COORD_BITS <= X_W) begin : g_narrow
    assign px = item.data.x[COORD_BITS-1:0];
    assign py = item.data.y[COORD_BITS-1:0];
  end else begin : g_wide
    assign px = COORD_BITS'($unsigned(item.data.x));
    assign py = COORD_BITS'($unsigned(item.data.y));
  end

  // Load decision terms, with a closed polygon treated as discarded
  logic [CNT_W-1:0]  cnt_eff;
  logic [DIST_W-1:0] rl_eff;
  logic              dup, full, too_few;
  logic [CNT_W:0]    total;
  logic [CMP_W-1:0]  a_w, b_w, c_w;
  always_comb begin
    cnt_eff = closed ? '0 : count;
    rl_eff  = closed ? '0 : running_length;
    dup     = item.data.last_vertex && px == first_x && py == first_y;
    total   = (CNT_W+1)'(cnt_eff) + (CNT_W+1)'(!dup);
    full    = !dup && (CNT_W+1)'(cnt_eff) >= (CNT_W+1)'(MAX_VERTICES);
    too_few = item.data.last_vertex && total < (CNT_W+1)'(3);
    a_w     = CMP_W'(item.data.pos_a);
    b_w     = CMP_W'(item.data.pos_b);
    c_w     = CMP_W'(count);
  end

  // Edge unit operands and saturating add
  logic                         e_start, e_done;
  logic signed [COORD_BITS-1:0] e_ax, e_ay, e_bx, e_by;
  logic [EL_W-1:0]              e_len;
  logic [DIST_W:0]              sum;
  logic [DIST_W-1:0]            rl_new;

  always_comb begin
    e_start = 1'b0;
    e_ax = px;      e_ay = py;
    e_bx = prev_x;  e_by = prev_y;
    if (state == S_IDLE && item.valid && item.data.op == OP_LOAD && cnt_eff != '0
        && !full && !too_few) begin
      e_start = 1'b1;
      if (dup) begin
        e_ax = first_x; e_ay = first_y;
      end
    end else if (state == S_EDGE && e_done && cur_last) begin
      e_start = 1'b1;
      e_ax = first_x; e_ay = first_y;
      e_bx = cur_x;   e_by = cur_y;
    end
    sum    = (DIST_W+1)'(running_length) + (DIST_W+1)'(e_len);
    rl_new = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  end

  pbd_edge #(.COORD_BITS(COORD_BITS)) u_edge (
    .clk   (clk),
    .rst   (rst),
    .start (e_start),
    .ax    (e_ax),
    .ay    (e_ay),
    .bx    (e_bx),
    .by    (e_by),
    .done  (e_done),
    .len   (e_len)
  );

  // Memory port selection
  always_comb begin
    wen   = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state)
      S_IDLE: begin
        wen = item.valid && item.data.op == OP_LOAD && cnt_eff == '0
              && !item.data.last_vertex;
      end
      S_EDGE: begin
        wen   = e_done;
        waddr = count[AW-1:0];
        wdata = rl_new;
      end
      S_CLOSE: begin
        wen   = e_done;
        wdata = rl_new;
      end
      S_RA:    raddr = qa;
      S_RB:    raddr = qb;
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) table_mem[waddr] <= wdata;
    rdata <= table_mem[raddr];
  end

  assign item.ready = (state == S_IDLE);

  // Query arithmetic: la and lb hold the position entries, rdata holds entry 0
  logic [DIST_W-1:0] la_eff, lb_eff, q_dist;
  always_comb begin
    la_eff = (qa == '0) ? '0 : la;
    lb_eff = (qb == '0) ? '0 : lb;
    q_dist = (qb > qa) ? lb - la_eff : rdata - la + lb_eff;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      running_length <= '0;
      closed         <= 1'b0;
      first_x        <= '0;
      first_y        <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
      result.valid   <= 1'b0;
    end else begin
      // Raise valid on emit, drop it once the beat is taken
      if (state == S_EMIT && (!result.valid || result.ready)) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            if (item.data.op == OP_LOAD) begin
              cur_x    <= px;
              cur_y    <= py;
              cur_last <= item.data.last_vertex;
              if (cnt_eff == '0) begin
                // First vertex, or a lone last vertex that closes nothing
                closed      <= 1'b0;
                pend_dist   <= '0;
                pend_shown  <= CNT_W'(1);
                state       <= S_EMIT;
                if (item.data.last_vertex) begin
                  pend_status    <= STATUS_TOO_FEW;
                  count          <= '0;
                  running_length <= '0;
                end else begin
                  pend_status    <= STATUS_OK;
                  first_x        <= px;
                  first_y        <= py;
                  prev_x         <= px;
                  prev_y         <= py;
                  running_length <= '0;
                  count          <= CNT_W'(1);
                end
              end else if (full) begin
                pend_status <= STATUS_FULL;
                pend_dist   <= rl_eff;
                pend_shown  <= cnt_eff;
                state       <= S_EMIT;
              end else if (too_few) begin
                pend_status    <= STATUS_TOO_FEW;
                pend_dist      <= '0;
                pend_shown     <= CNT_W'(total);
                count          <= '0;
                running_length <= '0;
                state          <= S_EMIT;
              end else begin
                pend_status <= STATUS_OK;
                state       <= dup ? S_CLOSE : S_EDGE;
              end
            end else begin
              qa         <= AW'(item.data.pos_a);
              qb         <= AW'(item.data.pos_b);
              pend_dist  <= '0;
              pend_shown <= count;
              if (!closed) begin
                pend_status <= STATUS_NO_POLY;
                state       <= S_EMIT;
              end else if (a_w >= c_w || b_w >= c_w) begin
                pend_status <= STATUS_RANGE;
                state       <= S_EMIT;
              end else begin
                pend_status <= STATUS_OK;
                state       <= (a_w != b_w) ? S_RA : S_EMIT;
              end
            end
          end
        end
        // Store the new prefix length and advance the vertex
        S_EDGE: begin
          if (e_done) begin
            running_length <= rl_new;
            count          <= count + 1'b1;
            prev_x         <= cur_x;
            prev_y         <= cur_y;
            pend_dist      <= rl_new;
            pend_shown     <= count + 1'b1;
            state          <= cur_last ? S_CLOSE : S_EMIT;
          end
        end
        // Add the closing edge and store the perimeter at entry 0
        S_CLOSE: begin
          if (e_done) begin
            running_length <= rl_new;
            closed         <= 1'b1;
            pend_dist      <= rl_new;
            pend_shown     <= count;
            state          <= S_EMIT;
          end
        end
        S_RA: state <= S_RB;
        S_RB: begin
          la    <= rdata;
          state <= S_R0;
        end
        S_R0: begin
          lb    <= rdata;
          state <= S_QD;
        end
        // Entry 0 is on the read port now; form the distance
        S_QD: begin
          pend_dist <= q_dist;
          state     <= S_EMIT;
        end
        // Hold the result until the output register is free
        S_EMIT: begin
          if (!result.valid || result.ready) begin
            result.data.status       <= pend_status;
            result.data.distance     <= pend_dist;
            result.data.vertex_count <= SHOWN_W'(pend_shown);
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/pbd_edge.sv */
// Edge length unit: floor(sqrt(dx*dx + dy*dy)) by shift-add squaring
// followed by a restoring square root, one bit per cycle. Uses no package.
module pbd_edge #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  output logic                         done,
  output logic [COORD_BITS:0]          len
);
  localparam int MW = COORD_BITS;
  localparam int SW = 2 * MW + 2;
  localparam int RB = SW / 2;
  localparam int CW = $clog2(RB + 1);

  typedef enum logic [1:0] {E_IDLE, E_SQ, E_ROOT} phase_t;

  phase_t          phase;
  logic [CW-1:0]   cnt;
  logic [SW-1:0]   mx, my, acc;
  logic [MW-1:0]   mulx, muly;
  logic [RB-1:0]   root;
  logic [RB+1:0]   rem;

  logic signed [MW:0] dx, dy;
  logic [MW-1:0]      magx, magy;
  logic [RB+1:0]      rem_sh, trial;
  logic               ge;

  // Magnitudes of the coordinate differences
  always_comb begin
    dx   = (MW+1)'(ax) - (MW+1)'(bx);
    dy   = (MW+1)'(ay) - (MW+1)'(by);
    magx = dx[MW] ? MW'(-dx) : MW'(dx);
    magy = dy[MW] ? MW'(-dy) : MW'(dy);
  end

  // One restoring root step
  always_comb begin
    rem_sh = {rem[RB-1:0], acc[SW-1 -: 2]};
    trial  = {root, 2'b01};
    ge     = rem_sh >= trial;
  end

  assign len = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= E_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (phase)
        E_IDLE: begin
          if (start) begin
            mx    <= SW'(magx);
            my    <= SW'(magy);
            mulx  <= magx;
            muly  <= magy;
            acc   <= '0;
            cnt   <= CW'(MW - 1);
            phase <= E_SQ;
          end
        end
        // Accumulate both squares, one multiplier bit a cycle
        E_SQ: begin
          acc  <= acc + (mulx[0] ? mx : '0) + (muly[0] ? my : '0);
          mx   <= mx << 1;
          my   <= my << 1;
          mulx <= mulx >> 1;
          muly <= muly >> 1;
          if (cnt == '0) begin
            root  <= '0;
            rem   <= '0;
            cnt   <= CW'(RB - 1);
            phase <= E_ROOT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        // Take one root bit per cycle, two radicand bits
        E_ROOT: begin
          rem  <= ge ? rem_sh - trial : rem_sh;
          root <= {root[RB-2:0], ge};
          acc  <= acc << 2;
          if (cnt == '0) begin
            done  <= 1'b1;
            phase <= E_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: phase <= E_IDLE;
      endcase
    end
  end
endmodule
